>>> rtl/core/haplotype_mec_scorer_macros.svh
// Assertion macros for the haplotype MEC scorer checker.
// Stand-alone header; no package or module dependencies.
`ifndef HAPLOTYPE_MEC_SCORER_MACROS_SVH
`define HAPLOTYPE_MEC_SCORER_MACROS_SVH

// Clocked assertion, off while reset is asserted (active-low reset).
`define HMS_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define HMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/hapmec_pkg.sv
// Types, widths and codes for the haplotype MEC scorer.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package hapmec_pkg;

  // Field widths
  localparam int PosW     = 18;
  localparam int AlleleW  = 2;
  localparam int ReqW     = 2;
  localparam int MisW     = 13;
  localparam int ScoreW   = 24;
  localparam int EpochW   = 3;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 18;
  localparam int SDataW   = 24;
  localparam int MDataW   = 24;

  // Allele codes
  localparam logic [AlleleW-1:0] AlleleZero = 2'd0;
  localparam logic [AlleleW-1:0] AlleleGap  = 2'd2;
  localparam logic [AlleleW-1:0] AlleleBad  = 2'd3;

  // Saturation limits
  localparam logic [MisW-1:0]   MisMax   = {MisW{1'b1}};
  localparam logic [ScoreW-1:0] ScoreMax = {ScoreW{1'b1}};

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgBlockStart = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgBlockEnd   = 1'd1;

  // Request kinds
  typedef enum logic [ReqW-1:0] {
    ReqLoad  = 2'd0,
    ReqFrag  = 2'd1,
    ReqStart = 2'd2
  } req_e;

  // One haplotype store entry: block epoch tag and both alleles
  typedef struct packed {
    logic [EpochW-1:0]  tag;
    logic [AlleleW-1:0] h1;
    logic [AlleleW-1:0] h2;
  } hap_entry_t;

  // Code three reads as gap
  function automatic logic [AlleleW-1:0] norm_allele(input logic [AlleleW-1:0] a);
    return (a == AlleleBad) ? AlleleGap : a;
  endfunction

endpackage

>>> rtl/core/haplotype_mec_scorer.sv
// Minimum error correction scorer for one phased haplotype block.
// Depends on hapmec_pkg; holds the haplotype store memory.
`timescale 1ns / 1ps

// Usage:
//  - Config channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) writes
//    block_start (index 0) and block_end (index 1); always ready. Write only
//    while no words are in flight.
//  - Input stream s_axis_*: tuser is the request kind (load, fragment allele,
//    start block), tlast ends a fragment, tdata carries position and alleles.
//  - Output stream m_axis_*: one word per input word, in order; tdata is the
//    running MEC total, tuser flags a word that closed a fragment.
//  - Pipeline: two register stages (input/memory read, then score update
//    into the output register). Throughput: one word per cycle when the
//    output is not stalled and no clearing pass runs or is pending, set by
//    the single read and single write port of the haplotype store.
//  - Reset: clears the counters and runs a clearing pass over all
//    MAX_BLOCK_LEN store entries with s_axis_tready low; config writes still go in.
//  - Start words retire the store contents by bumping an epoch tag; every
//    eighth start item wraps the tag and triggers the same clearing pass.
//  - When m_axis_tready is low the output word holds; one more word can sit
//    in the input stage, then s_axis_tready drops.
module haplotype_mec_scorer
  import hapmec_pkg::*;
#(
  parameter int MAX_BLOCK_LEN = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [SDataW-1:0]   s_axis_tdata,  // position[17:0], hap_one[19:18],
                                             // hap_two[21:20], read[23:22]
  input  logic [ReqW-1:0]     s_axis_tuser,  // req_type[1:0]
  input  logic                s_axis_tlast,  // last_in_fragment
  // output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [MDataW-1:0]   m_axis_tdata,  // mec_total[23:0]
  output logic [0:0]          m_axis_tuser   // fragment_closed[0]
);

  localparam int AW = $clog2(MAX_BLOCK_LEN);
  localparam logic [PosW-1:0] MaxLenPos = PosW'(MAX_BLOCK_LEN);
  localparam logic [AW-1:0]   LastAddr  = AW'(MAX_BLOCK_LEN - 1);

  // Block window registers
  logic [PosW-1:0] blk_start_q, blk_end_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_start_q <= '0;
      blk_end_q   <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgBlockStart) blk_start_q <= cfg_data_i;
      if (cfg_index_i == CfgBlockEnd)   blk_end_q   <= cfg_data_i;
    end
  end

  // Input word decode and block offset
  logic [PosW-1:0]    in_pos, in_off;
  logic               in_blk;
  logic [AlleleW-1:0] in_h1, in_h2, in_rd;

  assign in_pos = s_axis_tdata[PosW-1:0];
  assign in_h1  = norm_allele(s_axis_tdata[PosW+AlleleW-1:PosW]);
  assign in_h2  = norm_allele(s_axis_tdata[PosW+2*AlleleW-1:PosW+AlleleW]);
  assign in_rd  = norm_allele(s_axis_tdata[PosW+3*AlleleW-1:PosW+2*AlleleW]);
  assign in_off = in_pos - blk_start_q;
  assign in_blk = (in_pos >= blk_start_q) && (in_pos <= blk_end_q) && (in_off < MaxLenPos);

  // Pipeline control
  logic               v1_q, vo_q;
  logic               adv, accept, wrap_pend;
  logic [ReqW-1:0]    req1_q;
  logic               blk1_q, last1_q;
  logic [AW-1:0]      off1_q;
  logic [AlleleW-1:0] h1_1_q, h2_1_q, rd1_q;
  logic [EpochW-1:0]  epoch_q, epoch_d;
  logic               clr_q, clr_d;
  logic [AW-1:0]      clr_addr_q, clr_addr_d;

  assign adv       = v1_q && (!vo_q || m_axis_tready);
  assign wrap_pend = v1_q && (req1_q == ReqStart) && (epoch_q == {EpochW{1'b1}});
  assign s_axis_tready = !clr_q && !wrap_pend && (!v1_q || adv);
  assign accept    = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (accept) begin
      v1_q <= 1'b1;
    end else if (adv) begin
      v1_q <= 1'b0;
    end
  end

  // Input stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req1_q  <= s_axis_tuser;
      blk1_q  <= in_blk;
      off1_q  <= in_off[AW-1:0];
      h1_1_q  <= in_h1;
      h2_1_q  <= in_h2;
      rd1_q   <= in_rd;
      last1_q <= s_axis_tlast;
    end
  end

  // Haplotype store: one write port (load or clear), one registered read
  hap_entry_t hap_mem [MAX_BLOCK_LEN];
  hap_entry_t rdat_raw_q, fwd_dat_q, rdat;
  logic       fwd_q;
  logic       mem_we;
  logic [AW-1:0] mem_waddr;
  hap_entry_t mem_wdata;
  logic       load_wr;

  assign load_wr = adv && (req1_q == ReqLoad) && blk1_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = off1_q;
    mem_wdata = '{tag: epoch_q, h1: h1_1_q, h2: h2_1_q};
    if (clr_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '{tag: '0, h1: AlleleGap, h2: AlleleGap};
    end else if (load_wr) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) hap_mem[mem_waddr] <= mem_wdata;
    if (accept) rdat_raw_q <= hap_mem[in_off[AW-1:0]];
  end

  // Bypass a load retiring in the same cycle to the same offset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      fwd_q     <= load_wr && (off1_q == in_off[AW-1:0]);
      fwd_dat_q <= '{tag: epoch_q, h1: h1_1_q, h2: h2_1_q};
    end
  end

  assign rdat = fwd_q ? fwd_dat_q : rdat_raw_q;

  // Score state
  logic [MisW-1:0]    mis1_q, mis1_d, mis2_q, mis2_d, cnt1, cnt2, mmin;
  logic [ScoreW-1:0]  score_q, score_d;
  logic [ScoreW:0]    sum;
  logic               zero_q, zero_d, closed;
  logic               hit;
  logic [AlleleW-1:0] sh1, sh2;

  assign hit = (rdat.tag == epoch_q);
  assign sh1 = hit ? norm_allele(rdat.h1) : AlleleGap;
  assign sh2 = hit ? norm_allele(rdat.h2) : AlleleGap;

  // Fragment counting: saturating per-haplotype mismatches
  always_comb begin
    cnt1 = mis1_q;
    cnt2 = mis2_q;
    if ((rd1_q != AlleleGap) && blk1_q && !((sh1 == AlleleGap) && (sh2 == AlleleGap))) begin
      if ((sh1 != AlleleGap) && (sh1 != rd1_q) && (mis1_q != MisMax)) cnt1 = mis1_q + 1'b1;
      if ((sh2 != AlleleGap) && (sh2 != rd1_q) && (mis2_q != MisMax)) cnt2 = mis2_q + 1'b1;
    end
    mmin = (cnt1 < cnt2) ? cnt1 : cnt2;
    sum  = {1'b0, score_q} + (ScoreW+1)'(mmin);
  end

  // Per-word state update
  always_comb begin
    mis1_d     = mis1_q;
    mis2_d     = mis2_q;
    score_d    = score_q;
    zero_d     = zero_q;
    epoch_d    = epoch_q;
    closed     = 1'b0;
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == LastAddr) clr_d = 1'b0;
    end
    if (adv) begin
      case (req1_q)
        ReqLoad: begin
          if (blk1_q && ((h1_1_q == AlleleZero) || (h2_1_q == AlleleZero))) zero_d = 1'b1;
        end
        ReqFrag: begin
          if (last1_q) begin
            score_d = (sum > {1'b0, ScoreMax}) ? ScoreMax : sum[ScoreW-1:0];
            mis1_d  = '0;
            mis2_d  = '0;
            closed  = 1'b1;
          end else begin
            mis1_d = cnt1;
            mis2_d = cnt2;
          end
        end
        ReqStart: begin
          mis1_d  = '0;
          mis2_d  = '0;
          score_d = '0;
          zero_d  = 1'b0;
          epoch_d = epoch_q + 1'b1;
          if (epoch_q == {EpochW{1'b1}}) begin
            clr_d      = 1'b1;
            clr_addr_d = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mis1_q     <= '0;
      mis2_q     <= '0;
      score_q    <= '0;
      zero_q     <= 1'b0;
      epoch_q    <= '0;
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      mis1_q     <= mis1_d;
      mis2_q     <= mis2_d;
      score_q    <= score_d;
      zero_q     <= zero_d;
      epoch_q    <= epoch_d;
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // Output register
  logic [ScoreW-1:0] mec_q;
  logic              closed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (adv) begin
      vo_q <= 1'b1;
    end else if (m_axis_tready) begin
      vo_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mec_q    <= zero_d ? score_d : '0;
      closed_q <= closed;
    end
  end

  assign m_axis_tvalid   = vo_q;
  assign m_axis_tdata    = mec_q;
  assign m_axis_tuser[0] = closed_q;

endmodule

>>> rtl/core/hapmec_checker.sv
// Port-level checker for haplotype_mec_scorer, bound to the top level.
// Depends on hapmec_pkg and haplotype_mec_scorer_macros.svh.
`timescale 1ns / 1ps
`include "haplotype_mec_scorer_macros.svh"

module hapmec_checker
  import hapmec_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [MDataW-1:0]   m_axis_tdata,  // mec_total[23:0]
  input logic [0:0]          m_axis_tuser   // fragment_closed[0]
);

  // A stalled output word holds
  `HMS_ASSERT_RST(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output word changed while stalled")

  // A new output word comes from an earlier accepted input word
  `HMS_ASSERT_RST(a_out_src, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2), "output word without matching input")

  // No input taken while reset is asserted (store clearing pending)
  `HMS_ASSERT_ALWAYS(a_rst_block, clk_i, !rst_ni |-> !s_axis_tready, "input ready during reset")

endmodule

bind haplotype_mec_scorer hapmec_checker u_hapmec_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
